// ----- rtl/negb3_pkg.sv -----
package negb3_pkg;

  localparam int IN_W    = 32;
  localparam int VAL_W   = 36;
  localparam int NUM_POS = 21;
  localparam int POS_W   = 5;
  localparam int DIGIT_W = 2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t val_tab_t [NUM_POS];
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam digit_t DIG_ZERO = 2'd0;
  localparam digit_t DIG_ONE  = 2'd1;
  localparam digit_t DIG_TWO  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    logic last;
    pos_t pos;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    digit_t digit;
  } status_t;

  // (-3)^k
  function automatic longint weight(int k);
    longint p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 3;
    return ((k % 2) == 0) ? p : -p;
  endfunction

  // lowest / highest value reachable by digits at positions below k
  function automatic longint low_bound(int k);
    longint s;
    s = 0;
    for (int j = 0; j < k; j++) begin
      if ((j % 2) == 1) s = s + 2 * weight(j);
    end
    return s;
  endfunction

  function automatic longint high_bound(int k);
    longint s;
    s = 0;
    for (int j = 0; j < k; j++) begin
      if ((j % 2) == 0) s = s + 2 * weight(j);
    end
    return s;
  endfunction

  function automatic val_tab_t make_w1();
    val_tab_t t;
    for (int k = 0; k < NUM_POS; k++) t[k] = VAL_W'(weight(k));
    return t;
  endfunction

  function automatic val_tab_t make_w2();
    val_tab_t t;
    for (int k = 0; k < NUM_POS; k++) t[k] = VAL_W'(2 * weight(k));
    return t;
  endfunction

  // first threshold: edge of the lower-position range on the side the weight points to
  function automatic val_tab_t make_t1();
    val_tab_t t;
    for (int k = 0; k < NUM_POS; k++) begin
      t[k] = ((k % 2) == 0) ? VAL_W'(high_bound(k)) : VAL_W'(low_bound(k));
    end
    return t;
  endfunction

  function automatic val_tab_t make_t2();
    val_tab_t t;
    for (int k = 0; k < NUM_POS; k++) begin
      t[k] = ((k % 2) == 0) ? VAL_W'(high_bound(k) + weight(k))
                            : VAL_W'(low_bound(k) + weight(k));
    end
    return t;
  endfunction

  localparam val_tab_t W1_TAB = make_w1();
  localparam val_tab_t W2_TAB = make_w2();
  localparam val_tab_t T1_TAB = make_t1();
  localparam val_tab_t T2_TAB = make_t2();

endpackage

// ----- rtl/negb3_dp.sv -----
module negb3_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [negb3_pkg::IN_W-1:0] value_i,
  input  negb3_pkg::cmd_t                   cmd_i,
  output negb3_pkg::status_t                status_o,
  output logic [negb3_pkg::DIGIT_W-1:0]     digit_o,
  output logic                              last_o,
  output logic                              valid_o
);

  negb3_pkg::val_t   value_q, value_d;
  negb3_pkg::val_t   t1, t2, sub_amt;
  negb3_pkg::digit_t digit;
  logic              below1, below2;
  negb3_pkg::digit_t digit_q;
  logic              last_q, valid_q;

  assign t1 = negb3_pkg::T1_TAB[cmd_i.pos];
  assign t2 = negb3_pkg::T2_TAB[cmd_i.pos];

  // even position: weight > 0, digit grows as value climbs past the thresholds
  // odd position: weight < 0, mirror image
  always_comb begin
    if (cmd_i.pos[0]) begin
      below1 = (value_q >= t1);
      below2 = (value_q >= t2);
    end else begin
      below1 = (value_q <= t1);
      below2 = (value_q <= t2);
    end
    if (below1) begin
      digit = negb3_pkg::DIG_ZERO;
    end else if (below2) begin
      digit = negb3_pkg::DIG_ONE;
    end else begin
      digit = negb3_pkg::DIG_TWO;
    end
  end

  always_comb begin
    unique case (digit)
      negb3_pkg::DIG_ONE: sub_amt = negb3_pkg::W1_TAB[cmd_i.pos];
      negb3_pkg::DIG_TWO: sub_amt = negb3_pkg::W2_TAB[cmd_i.pos];
      default:            sub_amt = '0;
    endcase
  end

  always_comb begin
    value_d = value_q;
    if (cmd_i.load) begin
      value_d = {{(negb3_pkg::VAL_W-negb3_pkg::IN_W){value_i[negb3_pkg::IN_W-1]}}, value_i};
    end else if (cmd_i.step) begin
      value_d = value_q - sub_amt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      digit_q <= negb3_pkg::DIG_ZERO;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      value_q <= value_d;
      digit_q <= digit;
      last_q  <= cmd_i.last;
      valid_q <= cmd_i.emit;
    end
  end

  assign status_o.digit = digit;
  assign digit_o        = digit_q;
  assign last_o         = last_q;
  assign valid_o        = valid_q;

`ifndef ASSERT_OFF
  // all weight removed after the least significant position
  a_empty_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && cmd_i.pos == '0) |=> (value_q == '0))
    else $error("value not exhausted after position zero");
`endif

endmodule

// ----- rtl/negb3_ctrl.sv -----
module negb3_ctrl #(
  parameter int MAX_DIGITS = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  negb3_pkg::status_t status_i,
  output negb3_pkg::cmd_t    cmd_o,
  output logic               busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e          state_q, state_d;
  negb3_pkg::pos_t pos_q, pos_d;
  logic            started_q, started_d;
  logic            nonzero, at_bottom, in_window;

  assign nonzero   = (status_i.digit != negb3_pkg::DIG_ZERO);
  assign at_bottom = (pos_q == '0);
  assign in_window = (int'(pos_q) < MAX_DIGITS);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    started_d   = started_q;
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.emit  = 1'b0;
    cmd_o.last  = at_bottom;
    cmd_o.pos   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          pos_d      = negb3_pkg::POS_W'(negb3_pkg::NUM_POS - 1);
          started_d  = 1'b0;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        // leading zeros are suppressed, except the final digit of a zero
        cmd_o.emit = (started_q || nonzero || at_bottom) && in_window;
        started_d  = started_q || nonzero;
        // position parks at zero between runs so the tables stay in range
        if (at_bottom) begin
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      started_q <= started_d;
    end
  end

  assign busy_o = (state_q == ST_RUN);

`ifndef ASSERT_OFF
  a_load_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (!started_q && pos_q == negb3_pkg::POS_W'(negb3_pkg::NUM_POS - 1)))
    else $error("run not initialized at top position");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && at_bottom) |=> (state_q == ST_IDLE))
    else $error("run did not end after position zero");
`endif

endmodule

// ----- rtl/negabase3_converter.sv -----
// Base -3 converter. Pulse start_i while busy_o is low to hand in one signed
// 32-bit value_i; the block then walks the 21 digit positions from most to
// least significant, one position per clock, picking each digit by comparing
// the remaining value against constant thresholds of the range the lower
// positions can still reach, and subtracting digit * (-3)^k. Every position
// goes through the single subtract/compare datapath, and no new request is
// taken until the last position is done. Digits (0..2) appear on digit_o
// with valid_o high for exactly one cycle each, most significant first;
// leading zeros are dropped and last_o marks the least significant digit. A
// zero input gives one digit 0 with last_o set. The receiver cannot stall:
// it must take every digit in the cycle valid_o is high. If MAX_DIGITS is
// smaller than the value needs, only the MAX_DIGITS lowest digits are sent
// (including any zeros among them). The final digit may still be on the
// outputs when the next request is accepted.
module negabase3_converter #(
  parameter int MAX_DIGITS = 21
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [negb3_pkg::IN_W-1:0]   value_i,
  output logic                                valid_o,
  output logic [negb3_pkg::DIGIT_W-1:0]       digit_o,
  output logic                                last_o
);

  negb3_pkg::cmd_t    cmd;
  negb3_pkg::status_t status;

  // sequencer: position counter, leading-zero tracking, emit decisions
  negb3_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // value register, threshold compare, subtract, registered result
  negb3_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (value_i),
    .cmd_i    (cmd),
    .status_o (status),
    .digit_o  (digit_o),
    .last_o   (last_o),
    .valid_o  (valid_o)
  );

`ifndef ASSERT_OFF
  // the last digit leaves as the sequencer drops back to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("last digit while still busy");
  // outside a run only the final digit can be on the outputs
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !busy_o) |-> last_o)
    else $error("non-final digit while idle");
  // a digit is never 3
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (digit_o != 2'd3))
    else $error("digit out of range");
`endif

endmodule

// ----- dv/negabase3_converter_test.sv -----
`timescale 1ns / 100ps

// Testbench for the base -3 converter.
// One value goes in per request; the block answers with a run of digits,
// most significant first, one per strobe. A scoreboard works out the digit
// run of every accepted request and checks the strobed digits against it
// in order. The receiver side cannot stall, so only the sender idles.
module negabase3_converter_test #(
  parameter int DIGITS = 21  // digit window width handed to the block
);

  localparam int IN_W    = negb3_pkg::IN_W;
  localparam int DIGIT_W = negb3_pkg::DIGIT_W;

  typedef negb3_pkg::digit_t digit_t;

  // one digit of a run, as the block should strobe it
  typedef struct packed {
    digit_t digit;
    logic   last;
  } neg_digit_t;

  // Holds the digit runs still owed by the block, oldest first.
  class negabase_scoreboard;
    int unsigned max_digits;
    neg_digit_t  owed_digits[$];

    function new(int unsigned max_digits_arg);
      max_digits = max_digits_arg;
    endfunction

    // Remainder method: digit = value mod 3 in 0..2, value = (value - digit) / -3.
    // Digits come out least significant first, so the run is reversed on queueing.
    function void note_request(logic signed [IN_W-1:0] value_in);
      longint     rest;
      longint     rem;
      digit_t     low_first[$];
      neg_digit_t entry;
      rest = value_in;
      if (rest == 0) begin
        low_first.insert(low_first.size(), negb3_pkg::DIG_ZERO);
      end else begin
        // a window narrower than the value needs keeps only the low digits
        while (rest != 0 && low_first.size() < max_digits) begin
          rem = rest % 3;
          if (rem < 0) rem += 3;
          low_first.insert(low_first.size(), digit_t'(rem));
          rest = (rest - rem) / -3;
        end
      end
      for (int k = low_first.size() - 1; k >= 0; k--) begin
        entry.digit = low_first[k];
        entry.last  = (k == 0);
        owed_digits.insert(owed_digits.size(), entry);
      end
    endfunction

    // Empty string when the digit matches the oldest owed one.
    function string check_digit(logic [DIGIT_W-1:0] digit_in, logic last_in);
      neg_digit_t want;
      string      msg;
      msg = "";
      if (owed_digits.size() == 0) begin
        msg = $sformatf("digit %0d last %0b with no request pending", digit_in, last_in);
      end else begin
        want = owed_digits.pop_front();
        if (digit_in !== want.digit)
          msg = $sformatf("digit got %0d want %0d", digit_in, want.digit);
        if (last_in !== want.last)
          msg = {msg, $sformatf(" last got %0b want %0b", last_in, want.last)};
      end
      return msg;
    endfunction

    function int unsigned pending();
      return owed_digits.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, block under test
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [IN_W-1:0] value;
  logic digit_valid;
  logic [DIGIT_W-1:0] digit;
  logic digit_last;

  always #10 clk = ~clk;

  negabase3_converter #(
    .MAX_DIGITS(DIGITS)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start_i (start),
    .busy_o  (busy),
    .value_i (value),
    .valid_o (digit_valid),
    .digit_o (digit),
    .last_o  (digit_last)
  );

  negabase_scoreboard digit_sb = new(DIGITS);
  int unsigned mismatch_count = 0;

  // One line per mismatch, each one counted.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Digit monitor: the strobe lasts one cycle and cannot be held off, so each
  // edge with valid high is one digit. Values are read before the block's
  // own updates at that edge land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    string msg;
    if (rst_n === 1'b1 && digit_valid !== 1'b0) begin
      msg = digit_sb.check_digit(digit, digit_last);
      if (msg != "") report_mismatch(msg);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Hands one value in. Start may stay high from the previous request when no
  // idle gap is drawn; the request is taken at the first edge with busy low.
  task automatic send_value(input logic signed [IN_W-1:0] v, input bit allow_idle);
    if (allow_idle && $urandom_range(99) < 12) begin
      start <= 1'b0;
      // random gap lengths cross the conversion at every phase
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    digit_sb.note_request(v);
  endtask

  // Hold off until every owed digit has been strobed.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (digit_sb.pending() != 0);
  endtask

  // Mix of full-range values, small values around zero, values near powers of
  // three (long runs with many zero digits), single-bit patterns and values
  // near the ends of the 32-bit range.
  function automatic logic signed [IN_W-1:0] pick_value();
    int unsigned sel;
    longint      p;
    sel = $urandom_range(0, 9);
    case (sel)
      4, 5: begin
        return IN_W'(int'($urandom_range(0, 60)) - 30);
      end
      6, 7: begin
        p = 1;
        repeat ($urandom_range(0, 19)) p = p * 3;
        if ($urandom_range(1)) p = -p;
        p = p + int'($urandom_range(0, 4)) - 2;
        return IN_W'(p);
      end
      8: begin
        p = longint'(1) << $urandom_range(0, IN_W - 1);
        return $urandom_range(1) ? IN_W'(p) : ~IN_W'(p);
      end
      9: begin
        return $urandom_range(1) ? 32'sh7fffffff - IN_W'($urandom_range(0, 3))
                                 : 32'sh80000000 + IN_W'($urandom_range(0, 3));
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Directed values: zero, the smallest magnitudes of both signs, the range
  // ends, powers of -3 whose runs are mostly zero digits, runs of full length
  // and alternating bit patterns.
  localparam int NUM_DIRECTED = 22;
  localparam logic signed [IN_W-1:0] DIRECTED_VALUES [NUM_DIRECTED] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd3, -32'sd3, 32'sd4,
    32'sh7fffffff, 32'sh80000000, 32'sh80000001, 32'sh7ffffffe,
    32'sd9, -32'sd27, 32'sd81, 32'sd1162261467, -32'sd1162261467,
    32'sd387420489, -32'sd387420490, 32'sh55555555, 32'haaaaaaaa, 32'sd0
  };

  localparam int NUM_RANDOM = 200;

  initial begin
    int unsigned guard;
    start <= 1'b0;
    value <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, back to back
    foreach (DIRECTED_VALUES[i]) send_value(DIRECTED_VALUES[i], 1'b0);
    wait_drained();

    // random part; requests 60..119 go without idle gaps, and the sender
    // drains the block once more before request 140
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 140) wait_drained();
      send_value(pick_value(), !(n >= 60 && n < 120));
    end
    start <= 1'b0;

    // let the last runs come out
    guard = 0;
    while (digit_sb.pending() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (digit_sb.pending() != 0)
      report_mismatch($sformatf("%0d expected digits never came", digit_sb.pending()));

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The 222 requests plus their gaps fit well inside
  // this bound.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/negb3_pkg.sv
rtl/negb3_dp.sv
rtl/negb3_ctrl.sv
rtl/negabase3_converter.sv
dv/negabase3_converter_test.sv
